/* design/scrlex_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrlex_pkg
// Types, constants and per-character scanner functions of the script lexer.
// ----------------------------------------------------------------------------
package scrlex_pkg;

    localparam int MAX_TEXT = 65536;
    localparam logic [16:0] LEN_CAP = 17'((MAX_TEXT < 65536) ? MAX_TEXT : 65536);

    localparam int MAX_RES  = 3;
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    // token kinds
    localparam logic [2:0] KIND_WORD  = 3'd0;
    localparam logic [2:0] KIND_NUM   = 3'd1;
    localparam logic [2:0] KIND_FLOAT = 3'd2;
    localparam logic [2:0] KIND_XNUM  = 3'd3;
    localparam logic [2:0] KIND_OP    = 3'd4;
    localparam logic [2:0] KIND_STR   = 3'd5;
    localparam logic [2:0] KIND_CHR   = 3'd6;

    // record status
    localparam logic [1:0] ST_TOKEN   = 2'd0;
    localparam logic [1:0] ST_LETTER  = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;

    // characters
    localparam logic [7:0] CH_NONE   = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_EXCL   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DIG0   = 8'h30;
    localparam logic [7:0] CH_DIG9   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UPA    = 8'h41;
    localparam logic [7:0] CH_UPZ    = 8'h5A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOA    = 8'h61;
    localparam logic [7:0] CH_LOX    = 8'h78;
    localparam logic [7:0] CH_LOZ    = 8'h7A;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    typedef enum logic [10:0] {
        M_START = 11'b000_0000_0001,
        M_WORD  = 11'b000_0000_0010,
        M_NUM   = 11'b000_0000_0100,
        M_NUM2  = 11'b000_0000_1000,
        M_OP    = 11'b000_0001_0000,
        M_STR   = 11'b000_0010_0000,
        M_CHR   = 11'b000_0100_0000,
        M_WS    = 11'b000_1000_0000,
        M_LCOM  = 11'b001_0000_0000,
        M_BCOM  = 11'b010_0000_0000,
        M_STOP  = 11'b100_0000_0000
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  prev;
        logic [16:0] pos;
        logic [15:0] ostart;
        logic [16:0] olen;
        logic [2:0]  okind;
        logic        ovalid;
        logic        skip;
    } t_scan;

    localparam t_scan SCAN_RST = '{mode: M_START, prev: CH_NONE, pos: '0, ostart: '0,
                                   olen: '0, okind: KIND_WORD, ovalid: 1'b0, skip: 1'b0};

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [15:0] token_start;
        logic [16:0] token_length;
        logic [1:0]  status;
        logic        end_of_text;
    } t_tok;

    // records of one scanner call
    typedef struct packed {
        t_scan          s;
        logic [1:0]     n;
        t_tok [1:0]     r;
        logic           again;
    } t_proc;

    // records of one request, pushed into the result queue
    typedef struct packed {
        logic [1:0]           cnt;
        t_tok [MAX_RES-1:0]   tok;
    } t_push;

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= CH_LOA && c <= CH_LOZ) || (c >= CH_UPA && c <= CH_UPZ) || c == CH_UNDER;
    endfunction

    function automatic logic is_num(logic [7:0] c);
        return c >= CH_DIG0 && c <= CH_DIG9;
    endfunction

    function automatic logic is_special(logic [7:0] c);
        return (c > CH_SPACE && c < CH_DIG0) || (c > CH_DIG9 && c < CH_UPA) ||
               (c > CH_UPZ && c < CH_UNDER) || (c > CH_LOZ && c < CH_DEL);
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic logic pair_is_op(logic [7:0] a, logic [7:0] b);
        logic eq_pair;
        logic dbl_pair;
        eq_pair  = (b == CH_EQ) && (a == CH_PLUS || a == CH_MINUS || a == CH_STAR ||
                   a == CH_SLASH || a == CH_GT || a == CH_LT || a == CH_EQ ||
                   a == CH_PCT || a == CH_EXCL);
        dbl_pair = (b == a) && (a == CH_PLUS || a == CH_MINUS || a == CH_BAR || a == CH_AMP);
        return eq_pair || dbl_pair;
    endfunction

    function automatic logic [15:0] clip_start(logic [16:0] p);
        return p[16] ? 16'hFFFF : p[15:0];
    endfunction

    function automatic t_proc emit(t_proc p, t_tok t);
        t_proc q;
        q = p;
        if (q.n == 2'd0) begin
            q.r[0] = t;
        end else begin
            q.r[1] = t;
        end
        q.n = q.n + 2'd1;
        return q;
    endfunction

    function automatic t_proc close_tok(t_proc p);
        t_proc q;
        t_tok  t;
        q = p;
        t = '{token_kind: q.s.okind, token_start: q.s.ostart, token_length: q.s.olen,
              status: ST_TOKEN, end_of_text: 1'b0};
        if (q.s.ovalid) begin
            q = emit(q, t);
        end
        q.s.ovalid = 1'b0;
        return q;
    endfunction

    function automatic t_scan open_tok(t_scan s, logic [2:0] kind);
        t_scan r;
        r        = s;
        r.okind  = kind;
        r.ostart = clip_start(s.pos);
        r.olen   = 17'd1;
        r.ovalid = 1'b1;
        return r;
    endfunction

    function automatic t_scan grow(t_scan s);
        t_scan r;
        r = s;
        if (r.olen < LEN_CAP) begin
            r.olen = r.olen + 17'd1;
        end
        return r;
    endfunction

    function automatic t_scan consume(t_scan s, logic [7:0] c);
        t_scan r;
        r      = s;
        r.prev = c;
        if (r.pos < LEN_CAP) begin
            r.pos = r.pos + 17'd1;
        end
        return r;
    endfunction

    function automatic t_proc fail(t_proc p, logic [1:0] st);
        t_proc q;
        t_tok  t;
        q = close_tok(p);
        t = '{token_kind: KIND_WORD, token_start: clip_start(q.s.pos), token_length: '0,
              status: st, end_of_text: 1'b0};
        q = emit(q, t);
        q.s.mode = M_STOP;
        return q;
    endfunction

    // one pass of the state machine; again asks for a second pass from M_START
    function automatic t_proc scan_pass(t_proc p, logic [7:0] c, logic [7:0] la);
        t_proc q;
        q = p;
        q.again = 1'b0;
        case (p.s.mode)
            M_START: begin
                if (is_alpha(c) || c == CH_COLON) begin
                    q.s = open_tok(q.s, KIND_WORD);
                    q.s.mode = M_WORD;
                    q.s = consume(q.s, c);
                end else if (is_num(c)) begin
                    q.s = open_tok(q.s, KIND_NUM);
                    q.s.mode = M_NUM;
                    q.s = consume(q.s, c);
                end else if (is_space(c)) begin
                    q.s.mode = M_WS;
                    q.s = consume(q.s, c);
                end else if (is_special(c)) begin
                    if (c == CH_SLASH && (la == CH_SLASH || la == CH_STAR)) begin
                        q.s.mode = (la == CH_SLASH) ? M_LCOM : M_BCOM;
                        q.s.skip = 1'b1;
                    end else if (c == CH_DQUOTE) begin
                        q.s = open_tok(q.s, KIND_STR);
                        q.s.mode = M_STR;
                    end else if (c == CH_SQUOTE) begin
                        q.s = open_tok(q.s, KIND_CHR);
                        q.s.mode = M_CHR;
                    end else begin
                        q.s = open_tok(q.s, KIND_OP);
                        q.s.mode = M_OP;
                    end
                    q.s = consume(q.s, c);
                end else begin
                    q = fail(q, ST_ILLEGAL);
                end
            end
            M_WORD, M_NUM, M_NUM2: begin
                if (p.s.mode == M_WORD && (is_alpha(c) || is_num(c) || c == CH_COLON)) begin
                    q.s = consume(grow(q.s), c);
                end else if (p.s.mode == M_NUM && (c == CH_DOT || c == CH_LOX)) begin
                    q.s.okind = (c == CH_DOT) ? KIND_FLOAT : KIND_XNUM;
                    q.s = consume(grow(q.s), c);
                    q.s.mode = M_NUM2;
                end else if (p.s.mode != M_WORD && is_alpha(c)) begin
                    q = fail(q, ST_LETTER);
                end else if (p.s.mode != M_WORD && is_num(c)) begin
                    q.s = consume(grow(q.s), c);
                end else if (is_space(c)) begin
                    q = close_tok(q);
                    q.s.mode = M_WS;
                    q.s = consume(q.s, c);
                end else if (is_special(c)) begin
                    q = close_tok(q);
                    q.s.mode = M_START;
                    q.again = 1'b1;
                end else begin
                    q = fail(q, ST_ILLEGAL);
                end
            end
            M_OP: begin
                if (is_alpha(c) || is_num(c)) begin
                    q = close_tok(q);
                    q.s.mode = M_START;
                    q.again = 1'b1;
                end else if (is_space(c)) begin
                    q = close_tok(q);
                    q.s.mode = M_WS;
                    q.s = consume(q.s, c);
                end else if (is_special(c)) begin
                    if (pair_is_op(p.s.prev, c)) begin
                        q.s = consume(grow(q.s), c);
                    end else begin
                        q = close_tok(q);
                        q.s.mode = M_START;
                        q.again = 1'b1;
                    end
                end else begin
                    q = fail(q, ST_ILLEGAL);
                end
            end
            M_STR, M_CHR: begin
                q.s = grow(q.s);
                if (c == CH_BSLASH) begin
                    q.s.skip = 1'b1;
                end else if (c == ((p.s.mode == M_STR) ? CH_DQUOTE : CH_SQUOTE)) begin
                    q = close_tok(q);
                    q.s.mode = M_START;
                end
                q.s = consume(q.s, c);
            end
            M_WS: begin
                if (is_alpha(c) || is_num(c) || is_special(c)) begin
                    q.s.mode = M_START;
                    q.again = 1'b1;
                end else if (is_space(c)) begin
                    q.s = consume(q.s, c);
                end else begin
                    q = fail(q, ST_ILLEGAL);
                end
            end
            M_LCOM: begin
                if (c == CH_LF) begin
                    q.s.mode = M_START;
                end
                q.s = consume(q.s, c);
            end
            M_BCOM: begin
                if (p.s.prev == CH_STAR && c == CH_SLASH) begin
                    q.s.mode = M_START;
                end
                q.s = consume(q.s, c);
            end
            default: begin
            end
        endcase
        return q;
    endfunction

    // handles one character c with lookahead la
    function automatic t_proc scan_char(t_scan s, logic [7:0] c, logic [7:0] la);
        t_proc q;
        q = '{s: s, n: 2'd0, r: '0, again: 1'b0};
        if (s.mode != M_STOP) begin
            if (s.skip) begin
                q.s.skip = 1'b0;
                if (s.ovalid && (s.mode == M_STR || s.mode == M_CHR)) begin
                    q.s = grow(q.s);
                end
                q.s = consume(q.s, c);
            end else begin
                q = scan_pass(q, c, la);
                if (q.again) begin
                    q = scan_pass(q, c, la);
                end
            end
        end
        q.again = 1'b0;
        return q;
    endfunction

    function automatic t_push push_tok(t_push l, t_tok t);
        t_push r;
        r = l;
        if (r.cnt < 2'(MAX_RES)) begin
            r.tok[r.cnt] = t;
            r.cnt = r.cnt + 2'd1;
        end
        return r;
    endfunction

    function automatic t_push push_proc(t_push l, t_proc p);
        t_push r;
        r = l;
        for (int k = 0; k < 2; k++) begin
            if (2'(k) < p.n) begin
                r = push_tok(r, p.r[k]);
            end
        end
        return r;
    endfunction

endpackage

/* design/scrlex_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrlex_in_if
// Character channel: one source byte per request, with a last-byte flag.
// ----------------------------------------------------------------------------
interface scrlex_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

/* design/scrlex_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrlex_out_if
// Record channel: one token or error record per request.
// ----------------------------------------------------------------------------
interface scrlex_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [15:0] token_start;
    logic [16:0] token_length;
    logic [1:0]  status;
    logic        end_of_text;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output status, output end_of_text, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input status, input end_of_text, output ready);
endinterface

/* design/scrlex_res_q.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrlex_res_q
// Record queue: takes up to three records a cycle, pops one a cycle on ready.
// ----------------------------------------------------------------------------
module scrlex_res_q
    import scrlex_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_push         i_push,
    output logic          o_room,
    scrlex_out_if.source  o_out
);

    t_tok             r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wp;
    logic [RQ_AW-1:0] r_rp;
    logic [RQ_CW-1:0] r_cnt;
    logic             pop;
    t_tok             head;

    assign pop    = o_out.valid && o_out.ready;
    assign o_room = r_cnt <= RQ_CW'(RQ_DEPTH - MAX_RES);
    assign head   = r_mem[r_rp];

    assign o_out.valid        = r_cnt != '0;
    assign o_out.token_kind   = head.token_kind;
    assign o_out.token_start  = head.token_start;
    assign o_out.token_length = head.token_length;
    assign o_out.status       = head.status;
    assign o_out.end_of_text  = head.end_of_text;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + RQ_AW'(i_push.cnt);
            r_rp  <= r_rp + RQ_AW'(pop);
            r_cnt <= r_cnt + RQ_CW'(i_push.cnt) - RQ_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < RQ_DEPTH; i++) begin
            for (int k = 0; k < MAX_RES; k++) begin
                if (2'(k) < i_push.cnt && RQ_AW'(r_wp + RQ_AW'(k)) == RQ_AW'(i)) begin
                    r_mem[i] <= i_push.tok[k];
                end
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= RQ_CW'(RQ_DEPTH))
        else $error("result queue over depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.cnt != 2'd0 |-> o_room)
        else $error("records pushed without room");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_push.cnt == 2'd0 |=> r_cnt == $past(r_cnt) - RQ_CW'(1))
        else $error("queue count lost a pop");

endmodule

/* design/script_lexer_tokenizer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_lexer_tokenizer_core
// Script source scanner: one byte per request in, token and error records out.
//
//   channel  dir  payload                                             handshake
//   i_in     in   ch[7:0], last                                       valid/ready
//   o_out    out  token_kind, token_start, token_length, status,      valid/ready
//                 end_of_text
//
// One byte is taken per cycle while i_in.ready is high; each byte is scanned
// one request late, with the next byte as its lookahead, and the last byte
// flushes both plus a supplied newline. A request yields up to three records
// into a four-entry queue; i_in.ready is high while the queue has room for
// three, so byte intake stalls while more than one record waits in the queue.
// Synchronous active-low reset returns the scanner to its start state.
// ----------------------------------------------------------------------------
module script_lexer_tokenizer_core
    import scrlex_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    scrlex_in_if.sink     i_in,
    scrlex_out_if.source  o_out
);

    t_scan       r_scan;
    t_scan       n_scan;
    logic [7:0]  r_held;
    logic [7:0]  n_held;
    logic        r_held_v;
    logic        n_held_v;

    logic        room;
    logic        acc;
    t_proc       p_held;
    t_proc       p_ch;
    t_proc       p_nl;
    t_proc       p_end;
    t_push       recs;
    t_push       push;

    assign i_in.ready = room;
    assign acc        = i_in.valid && room;

    always_comb begin
        p_held = '{s: r_scan, n: 2'd0, r: '0, again: 1'b0};
        if (r_held_v) begin
            p_held = scan_char(r_scan, r_held, i_in.ch);
        end
        p_ch  = scan_char(p_held.s, i_in.ch, (i_in.ch != CH_LF) ? CH_LF : CH_NONE);
        p_nl  = p_ch;
        p_nl.n = 2'd0;
        if (i_in.ch != CH_LF) begin
            p_nl = scan_char(p_ch.s, CH_LF, CH_NONE);
        end
        p_end = p_nl;
        p_end.n = 2'd0;
        if (p_nl.s.mode != M_STOP) begin
            p_end = close_tok(p_end);
        end

        recs = '0;
        recs = push_proc(recs, p_held);
        if (i_in.last) begin
            recs = push_proc(recs, p_ch);
            recs = push_proc(recs, p_nl);
            recs = push_proc(recs, p_end);
            if (recs.cnt != 2'd0) begin
                recs.tok[recs.cnt - 2'd1].end_of_text = 1'b1;
            end
        end

        push = recs;
        if (!acc) begin
            push.cnt = 2'd0;
        end

        n_scan   = r_scan;
        n_held   = r_held;
        n_held_v = r_held_v;
        if (acc) begin
            if (i_in.last) begin
                n_scan   = SCAN_RST;
                n_held   = CH_NONE;
                n_held_v = 1'b0;
            end else begin
                n_scan   = p_held.s;
                n_held   = i_in.ch;
                n_held_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan   <= SCAN_RST;
            r_held   <= CH_NONE;
            r_held_v <= 1'b0;
        end else begin
            r_scan   <= n_scan;
            r_held   <= n_held;
            r_held_v <= n_held_v;
        end
    end

    scrlex_res_q u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_in.last |=> !r_held_v && r_scan.mode == M_START && r_scan.pos == '0)
        else $error("scanner not reset after last byte");

    a_held_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && !i_in.last |=> r_held_v && r_held == $past(i_in.ch))
        else $error("held byte not loaded");

    a_stop_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan.mode == M_STOP |-> !r_scan.ovalid)
        else $error("token left open after error");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for script_lexer_tokenizer_core. Source texts are fed
// one byte per request, last byte flagged. A scoreboard class runs its own
// byte-level scanner on every accepted byte and queues the token and error
// records it should cause; each record leaving the core is matched in order.
// Directed texts come first, then random texts built from well-formed token
// pieces with some noise, under changing idle rates and one long output
// hold-off.
// ----------------------------------------------------------------------------
module tb_top
    import scrlex_pkg::*;
();

    localparam int unsigned LEN_LIMIT   = (MAX_TEXT < 65536) ? MAX_TEXT : 65536;
    localparam int          RAND_ITEMS  = 380;
    localparam int          HOLD_CYCLES = 200;

    class token_tracker;
        t_mode       mode;
        logic [7:0]  held_ch;
        logic        held_v;
        logic [7:0]  prev_ch;
        int unsigned pos;
        logic [15:0] open_at;
        int unsigned open_len;
        logic [2:0]  open_kind;
        logic        open_v;
        logic        skip;
        t_tok        step_out[$];
        t_tok        pending_tokens[$];
        int          errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            mode      = M_START;
            held_ch   = CH_NONE;
            held_v    = 1'b0;
            prev_ch   = CH_NONE;
            pos       = 0;
            open_at   = '0;
            open_len  = 0;
            open_kind = KIND_WORD;
            open_v    = 1'b0;
            skip      = 1'b0;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= CH_LOA && c <= CH_LOZ) || (c >= CH_UPA && c <= CH_UPZ) ||
                   c == CH_UNDER;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_DIG0 && c <= CH_DIG9;
        endfunction

        function bit is_punct(logic [7:0] c);
            return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
                   (c >= 8'd91 && c <= 8'd94) || (c >= 8'd123 && c <= 8'd126);
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
        endfunction

        function bit joins_op(logic [7:0] a, logic [7:0] b);
            if (b == CH_EQ && (a == CH_PLUS || a == CH_MINUS || a == CH_STAR ||
                               a == CH_SLASH || a == CH_GT || a == CH_LT ||
                               a == CH_EQ || a == CH_PCT || a == CH_EXCL)) begin
                return 1'b1;
            end
            return b == a && (a == CH_PLUS || a == CH_MINUS || a == CH_BAR || a == CH_AMP);
        endfunction

        function logic [15:0] clipped(int unsigned p);
            return (p > 65535) ? 16'hFFFF : 16'(p);
        endfunction

        function void record(logic [2:0] kind, logic [15:0] start, int unsigned len,
                             logic [1:0] st);
            t_tok r;
            if (step_out.size() >= MAX_RES) begin
                return;
            end
            r.token_kind   = kind;
            r.token_start  = start;
            r.token_length = 17'(len);
            r.status       = st;
            r.end_of_text  = 1'b0;
            step_out.push_back(r);
        endfunction

        function void close_open();
            if (open_v) begin
                record(open_kind, open_at, open_len, ST_TOKEN);
            end
            open_v = 1'b0;
        endfunction

        function void open_new(logic [2:0] kind);
            open_kind = kind;
            open_at   = clipped(pos);
            open_len  = 1;
            open_v    = 1'b1;
        endfunction

        function void lengthen();
            if (open_len < LEN_LIMIT) begin
                open_len++;
            end
        endfunction

        function void advance(logic [7:0] c);
            prev_ch = c;
            if (pos < LEN_LIMIT) begin
                pos++;
            end
        endfunction

        function void stop_with(logic [1:0] st);
            close_open();
            record(KIND_WORD, clipped(pos), 0, st);
            mode = M_STOP;
        endfunction

        function void scan(logic [7:0] c, logic [7:0] la);
            bit again;
            if (mode == M_STOP) begin
                return;
            end
            if (skip) begin
                skip = 1'b0;
                if (open_v && (mode == M_STR || mode == M_CHR)) begin
                    lengthen();
                end
                advance(c);
                return;
            end
            for (int pass = 0; pass < 2; pass++) begin
                again = 1'b0;
                case (mode)
                    M_START: begin
                        if (is_letter(c) || c == CH_COLON) begin
                            open_new(KIND_WORD);
                            mode = M_WORD;
                            advance(c);
                        end else if (is_digit(c)) begin
                            open_new(KIND_NUM);
                            mode = M_NUM;
                            advance(c);
                        end else if (is_blank(c)) begin
                            mode = M_WS;
                            advance(c);
                        end else if (is_punct(c)) begin
                            if (c == CH_SLASH && (la == CH_SLASH || la == CH_STAR)) begin
                                mode = (la == CH_SLASH) ? M_LCOM : M_BCOM;
                                skip = 1'b1;
                            end else if (c == CH_DQUOTE) begin
                                open_new(KIND_STR);
                                mode = M_STR;
                            end else if (c == CH_SQUOTE) begin
                                open_new(KIND_CHR);
                                mode = M_CHR;
                            end else begin
                                open_new(KIND_OP);
                                mode = M_OP;
                            end
                            advance(c);
                        end else begin
                            stop_with(ST_ILLEGAL);
                        end
                    end
                    M_WORD, M_NUM, M_NUM2: begin
                        if (mode == M_WORD && (is_letter(c) || is_digit(c) || c == CH_COLON)) begin
                            lengthen();
                            advance(c);
                        end else if (mode == M_NUM && (c == CH_DOT || c == CH_LOX)) begin
                            open_kind = (c == CH_DOT) ? KIND_FLOAT : KIND_XNUM;
                            lengthen();
                            mode = M_NUM2;
                            advance(c);
                        end else if (mode != M_WORD && is_letter(c)) begin
                            stop_with(ST_LETTER);
                        end else if (mode != M_WORD && is_digit(c)) begin
                            lengthen();
                            advance(c);
                        end else if (is_blank(c)) begin
                            close_open();
                            mode = M_WS;
                            advance(c);
                        end else if (is_punct(c)) begin
                            close_open();
                            mode  = M_START;
                            again = 1'b1;
                        end else begin
                            stop_with(ST_ILLEGAL);
                        end
                    end
                    M_OP: begin
                        if (is_letter(c) || is_digit(c)) begin
                            close_open();
                            mode  = M_START;
                            again = 1'b1;
                        end else if (is_blank(c)) begin
                            close_open();
                            mode = M_WS;
                            advance(c);
                        end else if (is_punct(c)) begin
                            if (joins_op(prev_ch, c)) begin
                                lengthen();
                                advance(c);
                            end else begin
                                close_open();
                                mode  = M_START;
                                again = 1'b1;
                            end
                        end else begin
                            stop_with(ST_ILLEGAL);
                        end
                    end
                    M_STR, M_CHR: begin
                        lengthen();
                        if (c == CH_BSLASH) begin
                            skip = 1'b1;
                        end else if (c == ((mode == M_STR) ? CH_DQUOTE : CH_SQUOTE)) begin
                            close_open();
                            mode = M_START;
                        end
                        advance(c);
                    end
                    M_WS: begin
                        if (is_letter(c) || is_digit(c) || is_punct(c)) begin
                            mode  = M_START;
                            again = 1'b1;
                        end else if (is_blank(c)) begin
                            advance(c);
                        end else begin
                            stop_with(ST_ILLEGAL);
                        end
                    end
                    M_LCOM: begin
                        if (c == CH_LF) begin
                            mode = M_START;
                        end
                        advance(c);
                    end
                    M_BCOM: begin
                        if (prev_ch == CH_STAR && c == CH_SLASH) begin
                            mode = M_START;
                        end
                        advance(c);
                    end
                    default: begin
                    end
                endcase
                if (!again) begin
                    return;
                end
            end
        endfunction

        // one accepted request: byte c, final-byte flag fin
        function void take_char(logic [7:0] c, logic fin);
            step_out.delete();
            if (held_v) begin
                scan(held_ch, c);
            end
            if (!fin) begin
                held_ch = c;
                held_v  = 1'b1;
            end else begin
                scan(c, (c != CH_LF) ? CH_LF : CH_NONE);
                if (c != CH_LF) begin
                    scan(CH_LF, CH_NONE);
                end
                if (mode != M_STOP) begin
                    close_open();
                end
                if (step_out.size() > 0) begin
                    step_out[step_out.size() - 1].end_of_text = 1'b1;
                end
                clear();
            end
            foreach (step_out[k]) begin
                pending_tokens.push_back(step_out[k]);
            end
        endfunction

        function string show(t_tok t);
            return $sformatf("kind=%0d start=%0d len=%0d status=%0d eot=%0d", t.token_kind,
                             t.token_start, t.token_length, t.status, t.end_of_text);
        endfunction

        function void match_record(t_tok got);
            t_tok want;
            if (pending_tokens.size() == 0) begin
                $display("%0t: unexpected record: %s", $time, show(got));
                errors++;
                return;
            end
            want = pending_tokens.pop_front();
            if (got.token_kind != want.token_kind || got.token_start != want.token_start ||
                got.token_length != want.token_length || got.status != want.status ||
                got.end_of_text != want.end_of_text) begin
                $display("%0t: record mismatch: expected %s, actual %s", $time, show(want),
                         show(got));
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    scrlex_in_if  in_if ();
    scrlex_out_if out_if ();

    script_lexer_tokenizer_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    token_tracker tracker;
    t_tok         seen_rec;
    logic [7:0]   text_buf[$];
    int           tx_idle_pct = 13;
    int           rx_idle_pct = 61;
    int           holds_asked = 0;
    logic [7:0]   op_heads[11] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_GT, CH_LT,
                                   CH_EQ, CH_PCT, CH_EXCL, CH_BAR, CH_AMP};

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                seen_rec = '{token_kind: out_if.token_kind, token_start: out_if.token_start,
                             token_length: out_if.token_length, status: out_if.status,
                             end_of_text: out_if.end_of_text};
                tracker.match_record(seen_rec);
            end
            if (in_if.valid && in_if.ready) begin
                tracker.take_char(in_if.ch, in_if.last);
            end
        end
    end

    // record sink: random backpressure plus one long hold-off
    initial begin
        int hold_left;
        int holds_done;
        hold_left    = 0;
        holds_done   = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != holds_asked) begin
                holds_done = holds_asked;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_char(input logic [7:0] c, input logic fin);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            in_if.ch    <= 8'($urandom);
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.ch    <= c;
        in_if.last  <= fin;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    task automatic feed_text();
        for (int k = 0; k < text_buf.size(); k++) begin
            send_char(text_buf[k], k == text_buf.size() - 1);
        end
    endtask

    task automatic feed_string(input string s);
        text_buf.delete();
        for (int k = 0; k < s.len(); k++) begin
            text_buf.push_back(s[k]);
        end
        feed_text();
    endtask

    function automatic logic [7:0] digit();
        return CH_DIG0 + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(32, 126));
    endfunction

    function automatic logic [7:0] blank();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] word_char();
        case ($urandom_range(3))
            0:       return CH_LOA + 8'($urandom_range(25));
            1:       return CH_UPA + 8'($urandom_range(25));
            2:       return digit();
            default: return ($urandom_range(1) == 0) ? CH_UNDER : CH_COLON;
        endcase
    endfunction

    function automatic void add_piece();
        int         n;
        logic [7:0] head;
        n = $urandom_range(1, 5);
        case ($urandom_range(23))
            0, 1, 2, 3: begin
                text_buf.push_back(($urandom_range(3) == 0) ? CH_COLON :
                                   CH_LOA + 8'($urandom_range(25)));
                repeat (n - 1) text_buf.push_back(word_char());
            end
            4, 5: begin
                repeat (n) text_buf.push_back(digit());
            end
            6, 7: begin
                repeat (n) text_buf.push_back(digit());
                text_buf.push_back(($urandom_range(1) == 0) ? CH_DOT : CH_LOX);
                repeat ($urandom_range(3)) text_buf.push_back(digit());
            end
            8, 9, 10: begin
                head = op_heads[$urandom_range(10)];
                case ($urandom_range(4))
                    0: text_buf.push_back(head);
                    1: begin
                        text_buf.push_back(head);
                        text_buf.push_back(CH_EQ);
                    end
                    2: begin
                        text_buf.push_back(head);
                        text_buf.push_back(head);
                    end
                    3: begin
                        text_buf.push_back(head);
                        text_buf.push_back(CH_EQ);
                        text_buf.push_back(CH_EQ);
                    end
                    default: begin
                        case ($urandom_range(3))
                            0:       text_buf.push_back(8'($urandom_range(33, 47)));
                            1:       text_buf.push_back(8'($urandom_range(58, 64)));
                            2:       text_buf.push_back(8'($urandom_range(91, 94)));
                            default: text_buf.push_back(8'($urandom_range(123, 126)));
                        endcase
                    end
                endcase
            end
            11, 12: begin
                text_buf.push_back(CH_DQUOTE);
                repeat (n - 1) begin
                    if ($urandom_range(3) == 0) begin
                        text_buf.push_back(CH_BSLASH);
                    end
                    text_buf.push_back(printable());
                end
                if ($urandom_range(9) != 0) begin
                    text_buf.push_back(CH_DQUOTE);
                end
            end
            13: begin
                text_buf.push_back(CH_SQUOTE);
                if ($urandom_range(2) == 0) begin
                    text_buf.push_back(CH_BSLASH);
                end
                text_buf.push_back(printable());
                text_buf.push_back(CH_SQUOTE);
            end
            14, 15, 16, 17: begin
                repeat (n) text_buf.push_back(blank());
            end
            18: begin
                text_buf.push_back(CH_SLASH);
                text_buf.push_back(CH_SLASH);
                repeat (n) text_buf.push_back(printable());
                if ($urandom_range(4) != 0) begin
                    text_buf.push_back(CH_LF);
                end
            end
            19: begin
                text_buf.push_back(CH_SLASH);
                text_buf.push_back(CH_STAR);
                repeat (n) text_buf.push_back(($urandom_range(3) == 0) ? CH_STAR : printable());
                text_buf.push_back(CH_STAR);
                text_buf.push_back(CH_SLASH);
            end
            20: begin
                repeat (n) text_buf.push_back(digit());
                text_buf.push_back(CH_UPA + 8'($urandom_range(25)));
            end
            21: begin
                text_buf.push_back(8'($urandom_range(255)));
            end
            default: begin
                text_buf.push_back(($urandom_range(1) == 0) ? CH_UNDER :
                                   CH_UPA + 8'($urandom_range(25)));
                repeat (n - 1) text_buf.push_back(word_char());
            end
        endcase
    endfunction

    function automatic void build_text();
        text_buf.delete();
        repeat ($urandom_range(1, 7)) begin
            add_piece();
            if ($urandom_range(1) == 0) begin
                text_buf.push_back(blank());
            end
        end
        if ($urandom_range(2) == 0) begin
            text_buf.push_back(CH_LF);
        end
        while (text_buf.size() > 40) begin
            void'(text_buf.pop_back());
        end
    endfunction

    initial begin
        int rand_items;
        int phase;
        rand_items   = 0;
        phase        = 0;
        tracker      = new();
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.ch     = CH_NONE;
        in_if.last   = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // word, float, x-number, operator grown by pairs
        feed_string("Z 1.5 2x9+=");
        // char literal, then an escaped quote leaving a string open to the end
        feed_string("'c'\"\\\"");
        // comment closed by the star of its own opener: no records at all
        feed_string("/*/");
        // letter inside a number
        feed_string("1a");
        // illegal byte after an operator, then a stopped scanner
        text_buf.delete();
        text_buf.push_back(CH_PLUS);
        text_buf.push_back(8'hFF);
        text_buf.push_back(CH_LOA + 8'd16);
        feed_text();

        while (rand_items < RAND_ITEMS) begin
            if (rand_items >= 2 * RAND_ITEMS / 3 && phase != 2) begin
                phase       = 2;
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                holds_asked++;
            end else if (rand_items >= RAND_ITEMS / 3 && phase == 0) begin
                phase       = 1;
                tx_idle_pct = 61;
                rx_idle_pct = 13;
            end
            build_text();
            feed_text();
            rand_items += text_buf.size();
        end

        in_if.valid <= 1'b0;
        while (tracker.pending_tokens.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
design/scrlex_pkg.sv
design/scrlex_in_if.sv
design/scrlex_out_if.sv
design/scrlex_res_q.sv
design/script_lexer_tokenizer_core.sv
verif/tb_top.sv
